// ===== rtl/ihq_pkg.sv =====
// ----------------------------------------------------------------------------
// ihq_pkg
// Shared types and codes for the indexed min-heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ihq_pkg;

  localparam int NODE_W   = 10;
  localparam int IN_KEY_W = 32;
  localparam int COUNT_W  = 11;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]          op;
    logic [NODE_W-1:0]   node_id;
    logic [IN_KEY_W-1:0] key;
  } req_item_t;

  typedef struct packed {
    logic                found;
    logic [NODE_W-1:0]   out_node;
    logic [IN_KEY_W-1:0] out_key;
    logic [COUNT_W-1:0]  count;
    logic                full_drop;
  } rsp_item_t;

endpackage

`default_nettype wire

// ===== rtl/ihq_ram.sv =====
// ----------------------------------------------------------------------------
// ihq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ihq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/indexed_min_heap_queue_core.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_core
// Indexed binary min-heap with decrease/increase key for shortest-path search.
// ----------------------------------------------------------------------------
// One item is one operation: push/update, pop, peek or clear; every item
// yields exactly one result item. The heap entries live in one RAM, the
// node-to-position table in a second RAM; one read port each, registered
// read. A small sequencer walks the heap one level at a time: sift-down
// steps through left child read, right child read, compare and move at each
// level (with no right child it moves after the left read), sift-up through
// parent read, compare and move. An update may walk both directions. Clear
// and a pop or peek of an empty heap go straight to the result.
// The block takes no new item until the result is loaded.
// Node presence is derived, not stored: a node is present when its table
// position lies below the entry count and the heap entry there carries that
// node. After reset the position table is swept to zero, one entry per
// cycle; req_stall stays high during the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_queue_core #(
  parameter int CAPACITY   = 1024,
  parameter int NODE_COUNT = 1024,
  parameter int KEY_BITS   = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire ihq_pkg::req_item_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output ihq_pkg::rsp_item_t     rsp
);

  import ihq_pkg::*;

  localparam int HA_W  = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NA_W  = $clog2(NODE_COUNT);
  localparam int CW    = HA_W + 2;
  localparam int EW    = NODE_W + KEY_BITS;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_PQ   = 4'd2;
  localparam logic [3:0] S_PH   = 4'd3;
  localparam logic [3:0] S_NEW  = 4'd4;
  localparam logic [3:0] S_TOP  = 4'd5;
  localparam logic [3:0] S_LAST = 4'd6;
  localparam logic [3:0] S_DN0  = 4'd7;
  localparam logic [3:0] S_DN1  = 4'd8;
  localparam logic [3:0] S_DN2  = 4'd9;
  localparam logic [3:0] S_UP0  = 4'd10;
  localparam logic [3:0] S_UP1  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  // Sequencer state
  logic [3:0]          state;
  logic [NA_W-1:0]     clr_idx;
  logic [CNT_W-1:0]    cnt;
  logic [1:0]          op_r;
  logic [HA_W-1:0]     pos;
  logic [NODE_W-1:0]   cur_node;
  logic [KEY_BITS-1:0] cur_key;
  entry_t              best;
  logic                res_found;
  logic [NODE_W-1:0]   res_node;
  logic [IN_KEY_W-1:0] res_key;
  logic                res_drop;

  // RAM ports
  logic            h_we, p_we;
  logic [HA_W-1:0] h_waddr, h_raddr;
  entry_t          h_wdata, h_rd;
  logic [EW-1:0]   h_rdata;
  logic [NA_W-1:0] p_waddr, p_raddr;
  logic [HA_W-1:0] p_wdata, p_rdata;

  assign h_rd = h_rdata;

  ihq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
    .clk  (clk),
    .we   (h_we),
    .waddr(h_waddr),
    .wdata(h_wdata),
    .raddr(h_raddr),
    .rdata(h_rdata)
  );

  ihq_ram #(.WIDTH(HA_W), .DEPTH(NODE_COUNT)) u_pos (
    .clk  (clk),
    .we   (p_we),
    .waddr(p_waddr),
    .wdata(p_wdata),
    .raddr(p_raddr),
    .rdata(p_rdata)
  );

  // Heap index arithmetic, one level at a time
  logic [CW-1:0]   child_w, other_w;
  logic [HA_W-1:0] child, other, parent;
  logic            down_go, has_other;
  logic            node_ok, pos_hit, full;
  entry_t          cand;
  logic [HA_W-1:0] cand_pos;
  logic            move_dn, move_up;

  always_comb begin
    child_w   = {1'b0, pos, 1'b1};
    other_w   = child_w + CW'(1);
    child     = child_w[HA_W-1:0];
    other     = other_w[HA_W-1:0];
    parent    = HA_W'((pos - HA_W'(1)) >> 1);
    down_go   = CW'(pos) < CW'(cnt >> 1);
    has_other = other_w < CW'(cnt);
    node_ok   = 32'(req.node_id) < NODE_COUNT;
    pos_hit   = CW'(p_rdata) < CW'(cnt);
    full      = CW'(cnt) >= CW'(CAPACITY);
    // pick the smaller child; the right one only when strictly smaller
    if (state == S_DN2 && h_rd.key < best.key) begin
      cand     = h_rd;
      cand_pos = other;
    end else if (state == S_DN2) begin
      cand     = best;
      cand_pos = child;
    end else begin
      cand     = h_rd;
      cand_pos = child;
    end
    move_dn = cand.key < cur_key;
    move_up = cur_key < h_rd.key;
  end

  // RAM address and write control
  always_comb begin
    h_raddr = '0;
    p_raddr = NA_W'(req.node_id);
    h_we    = 1'b0;
    h_waddr = pos;
    h_wdata = cand;
    p_we    = 1'b0;
    p_waddr = NA_W'(cand.node);
    p_wdata = pos;
    unique case (state)
      S_CLR: begin
        p_we    = 1'b1;
        p_waddr = clr_idx;
        p_wdata = '0;
      end
      S_PQ:  h_raddr = p_rdata;
      S_TOP: h_raddr = HA_W'(cnt - CNT_W'(1));
      S_DN0: h_raddr = child;
      S_DN1: begin
        h_raddr = other;
        if (!has_other && move_dn) begin
          h_we = 1'b1;
          p_we = 1'b1;
        end
      end
      S_DN2: begin
        if (move_dn) begin
          h_we = 1'b1;
          p_we = 1'b1;
        end
      end
      S_UP0: h_raddr = parent;
      S_UP1: begin
        h_wdata = h_rd;
        p_waddr = NA_W'(h_rd.node);
        if (move_up) begin
          h_we = 1'b1;
          p_we = 1'b1;
        end
      end
      S_FIN: begin
        h_we         = 1'b1;
        h_wdata.node = cur_node;
        h_wdata.key  = cur_key;
        p_we         = 1'b1;
        p_waddr      = NA_W'(cur_node);
      end
      default: ;
    endcase
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // S_DONE reloads the result register itself
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + NA_W'(1);
          if (clr_idx == NA_W'(NODE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op_r      <= req.op;
            cur_node  <= req.node_id;
            cur_key   <= KEY_BITS'(req.key);
            res_found <= 1'b0;
            res_node  <= '0;
            res_key   <= '0;
            res_drop  <= 1'b0;
            unique case (req.op)
              OP_PUSH:  state <= node_ok ? S_PQ : S_DONE;
              OP_POP,
              OP_PEEK:  state <= (cnt == '0) ? S_DONE : S_TOP;
              OP_CLEAR: begin
                cnt   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_PQ: begin
          pos   <= p_rdata;
          state <= pos_hit ? S_PH : S_NEW;
        end
        S_PH: state <= (h_rd.node == cur_node) ? S_DN0 : S_NEW;
        S_NEW: begin
          if (full) begin
            res_drop <= 1'b1;
            state    <= S_DONE;
          end else begin
            pos   <= HA_W'(cnt);
            cnt   <= cnt + CNT_W'(1);
            state <= S_UP0;
          end
        end
        S_TOP: begin
          res_found <= 1'b1;
          res_node  <= h_rd.node;
          res_key   <= IN_KEY_W'(h_rd.key);
          if (op_r == OP_PEEK) begin
            state <= S_DONE;
          end else begin
            cnt   <= cnt - CNT_W'(1);
            state <= (cnt == CNT_W'(1)) ? S_DONE : S_LAST;
          end
        end
        S_LAST: begin
          cur_node <= h_rd.node;
          cur_key  <= h_rd.key;
          pos      <= '0;
          state    <= S_DN0;
        end
        S_DN0: begin
          if (down_go) begin
            state <= S_DN1;
          end else begin
            state <= (op_r == OP_PUSH) ? S_UP0 : S_FIN;
          end
        end
        S_DN1: begin
          if (has_other) begin
            best  <= h_rd;
            state <= S_DN2;
          end else if (move_dn) begin
            pos   <= cand_pos;
            state <= S_DN0;
          end else begin
            state <= (op_r == OP_PUSH) ? S_UP0 : S_FIN;
          end
        end
        S_DN2: begin
          if (move_dn) begin
            pos   <= cand_pos;
            state <= S_DN0;
          end else begin
            state <= (op_r == OP_PUSH) ? S_UP0 : S_FIN;
          end
        end
        S_UP0: state <= (pos == '0) ? S_FIN : S_UP1;
        S_UP1: begin
          if (move_up) begin
            pos   <= parent;
            state <= S_UP0;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: state <= S_DONE;
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid     <= 1'b1;
            rsp.found     <= res_found;
            rsp.out_node  <= res_node;
            rsp.out_key   <= res_key;
            rsp.count     <= COUNT_W'(cnt);
            rsp.full_drop <= res_drop;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
